[rtl/csm_pkg.sv]
// Shared constants and types for the circular skip-mask track pointer.
`default_nettype none

package csm_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 256;

	localparam int unsigned MODE_W  = 3;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned COUNT_W = 9;

	localparam logic [MODE_W-1:0] MODE_SELECT  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_NEXT    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PREV    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MARK    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RESTART = 3'd4;

	typedef struct packed {
		logic shift;
		logic tail_mark;
	} ring_ctl_t;

endpackage

`default_nettype wire

[rtl/circular_skip_mask_track_pointer.sv]
// Top level: pointer control, lap scan over the mark ring and result register.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------------
//  cfg     | cfg_valid / cfg_ready  | cfg_track_count
//  in      | in_valid / in_stall    | mode, index
//  out     | out_valid / out_stall  | ok, current_valid, current_index, playable_count,
//          |                        | index_bad
//
//  Each item runs one lap of the mark ring, one cell per cycle, between accept and
//  finish. A next, previous or mark step with a current entry and a non-empty list
//  first reduces the pointer below the entry count by repeated subtraction, then
//  compares and starts the lap.
//  Reset clears all marks, the pointer and the entry count; no clearing pass.
//  A new item is taken while a result waits; the finish waits on a stalled result.
`default_nettype none

module circular_skip_mask_track_pointer import csm_pkg::*; #(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [COUNT_W-1:0] cfg_track_count,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [MODE_W-1:0]  mode,
	input  wire  [INDEX_W-1:0] index,
	output logic               out_valid,
	input  wire                out_stall,
	output logic               ok,
	output logic               current_valid,
	output logic [INDEX_W-1:0] current_index,
	output logic [COUNT_W-1:0] playable_count,
	output logic               index_bad
);

	localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_LAP  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]         state_q;
	logic [COUNT_W-1:0] track_count_q;
	logic [COUNT_W-1:0] n;
	logic [IW-1:0]      pointer_q;
	logic               pointer_valid_q;
	logic [MODE_W-1:0]  mode_q;
	logic [INDEX_W-1:0] idx_q;
	logic [IW-1:0]      base_q;
	logic [IW-1:0]      j_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               idx_bad_q;
	logic               fa_f_q, ff_f_q, bb_f_q, bl_f_q;
	logic [IW-1:0]      fa_v_q, ff_v_q, bb_v_q, bl_v_q;
	logic               out_valid_q;

	logic      accept;
	logic      walk_en;
	logic      head;
	logic      new_mark;
	logic      in_range;
	logic      unmarked;
	logic      finish;
	ring_ctl_t ring_ctl;

	logic          nx_ok;
	logic          nx_valid;
	logic [IW-1:0] nx_pointer;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign finish    = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	assign n = (32'(track_count_q) > 32'(MAX_ENTRIES)) ? COUNT_W'(MAX_ENTRIES)
	                                                   : track_count_q;

	assign walk_en = pointer_valid_q && (n != '0) &&
	                 (mode == MODE_NEXT || mode == MODE_PREV || mode == MODE_MARK);

	// Mark seen at the head this cycle, after the operation's write.
	always_comb begin
		new_mark = head;
		if (mode_q == MODE_RESTART) begin
			new_mark = 1'b0;
		end else if (mode_q == MODE_MARK && pointer_valid_q && j_q == pointer_q) begin
			new_mark = 1'b1;
		end
	end

	assign in_range = 32'(j_q) < 32'(n);
	assign unmarked = in_range && !new_mark;

	assign ring_ctl.shift     = (state_q == ST_LAP);
	assign ring_ctl.tail_mark = new_mark;

	csm_ring #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.head   (head)
	);

	always_comb begin
		nx_ok      = 1'b0;
		nx_valid   = pointer_valid_q;
		nx_pointer = pointer_q;
		unique case (mode_q)
			MODE_SELECT: begin
				if (32'(idx_q) < 32'(n) && !idx_bad_q) begin
					nx_ok      = 1'b1;
					nx_valid   = 1'b1;
					nx_pointer = IW'(idx_q);
				end
			end
			MODE_NEXT: begin
				if (pointer_valid_q) begin
					nx_ok      = fa_f_q || ff_f_q;
					nx_pointer = fa_f_q ? fa_v_q : (ff_f_q ? ff_v_q : pointer_q);
				end
			end
			MODE_PREV: begin
				if (pointer_valid_q) begin
					nx_ok      = bb_f_q || bl_f_q;
					nx_pointer = bb_f_q ? bb_v_q : (bl_f_q ? bl_v_q : pointer_q);
				end
			end
			MODE_MARK: begin
				if (pointer_valid_q) begin
					nx_ok = fa_f_q || ff_f_q;
					if (fa_f_q) begin
						nx_pointer = fa_v_q;
					end else if (ff_f_q) begin
						nx_pointer = ff_v_q;
					end else begin
						nx_valid   = 1'b0;
						nx_pointer = '0;
					end
				end
			end
			MODE_RESTART: begin
				nx_ok      = 1'b1;
				nx_valid   = (n != '0);
				nx_pointer = '0;
			end
			default: begin
				nx_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			track_count_q <= cfg_track_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			pointer_q       <= '0;
			pointer_valid_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= walk_en ? ST_MOD : ST_LAP;
					end
				end
				ST_MOD: begin
					if (32'(base_q) < 32'(n)) begin
						state_q <= ST_LAP;
					end
				end
				ST_LAP: begin
					if (j_q == IW'(MAX_ENTRIES - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (finish) begin
						state_q         <= ST_IDLE;
						pointer_q       <= nx_pointer;
						pointer_valid_q <= nx_valid;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Scan registers: item capture, base reduction and lap accumulation.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= mode;
			idx_q     <= index;
			base_q    <= pointer_q;
			j_q       <= '0;
			cnt_q     <= '0;
			idx_bad_q <= 1'b0;
			fa_f_q    <= 1'b0;
			ff_f_q    <= 1'b0;
			bb_f_q    <= 1'b0;
			bl_f_q    <= 1'b0;
		end else if (state_q == ST_MOD) begin
			if (32'(base_q) >= 32'(n)) begin
				base_q <= base_q - IW'(n);
			end
		end else if (state_q == ST_LAP) begin
			j_q <= j_q + IW'(1);
			if (unmarked) begin
				cnt_q <= cnt_q + COUNT_W'(1);
				if (j_q > base_q && !fa_f_q) begin
					fa_f_q <= 1'b1;
					fa_v_q <= j_q;
				end
				if (!ff_f_q) begin
					ff_f_q <= 1'b1;
					ff_v_q <= j_q;
				end
				if (j_q < base_q) begin
					bb_f_q <= 1'b1;
					bb_v_q <= j_q;
				end
				bl_f_q <= 1'b1;
				bl_v_q <= j_q;
			end
			if (in_range && 32'(j_q) == 32'(idx_q)) begin
				idx_bad_q <= new_mark;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			ok             <= nx_ok;
			current_valid  <= nx_valid;
			current_index  <= nx_valid ? INDEX_W'(nx_pointer) : '0;
			playable_count <= cnt_q;
			index_bad      <= idx_bad_q;
		end
	end

endmodule

`default_nettype wire

[rtl/csm_cell.sv]
// One bad-mark cell of the rotating mark ring.
`default_nettype none

module csm_cell (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  shift,
	input  wire  d,
	output logic q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= 1'b0;
		end else if (shift) begin
			q <= d;
		end
	end

endmodule

`default_nettype wire

[rtl/csm_ring.sv]
// Ring of mark cells rotating towards the head, rewritten at the tail.
`default_nettype none

module csm_ring import csm_pkg::*; #(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	input  ring_ctl_t ctl,
	output logic      head
);

	logic [MAX_ENTRIES-1:0] mark;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic d;
		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign d = ctl.tail_mark;
		end else begin : g_mid
			assign d = mark[i+1];
		end
		csm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ctl.shift),
			.d      (d),
			.q      (mark[i])
		);
	end

	assign head = mark[0];

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the circular skip-mask track pointer.
`default_nettype none

module testbench;
	import csm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ENTRIES_MAX  = 256;
	localparam int unsigned LIMIT_CYCLES = 4_000_000;
	localparam int unsigned DRAIN_CYCLES = 600;
	localparam int unsigned HOLD_CYCLES  = 1500;
	localparam int unsigned PHASES       = 16;
	localparam int unsigned PHASE_ITEMS  = 106;

	typedef struct packed {
		logic               ok;
		logic               current_valid;
		logic [INDEX_W-1:0] current_index;
		logic [COUNT_W-1:0] playable_count;
		logic               index_bad;
	} track_result_t;

	class track_pointer_scoreboard;
		bit                 marks [ENTRIES_MAX];
		logic [INDEX_W-1:0] ptr;
		bit                 ptr_valid;
		logic [COUNT_W-1:0] track_count;
		track_result_t      expected_results [$];
		int unsigned        errors;
		int unsigned        checked;

		function new();
			foreach (marks[i])
				marks[i] = 0;
			ptr = '0;
			ptr_valid = 0;
			track_count = '0;
			errors = 0;
			checked = 0;
		endfunction

		function int unsigned entries_in_use();
			return (track_count > ENTRIES_MAX) ? ENTRIES_MAX : int'(track_count);
		endfunction

		function void set_track_count(logic [COUNT_W-1:0] value);
			track_count = value;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		// step forward or backward to the nearest unmarked entry, wrapping round the list
		function bit walk_to_playable(bit backward);
			int unsigned n;
			int unsigned base;
			int unsigned cand;
			n = entries_in_use();
			if (!ptr_valid || n == 0)
				return 0;
			base = ptr % n;
			for (int unsigned k = 1; k <= n; k++) begin
				cand = backward ? (base + n - (k % n)) % n : (base + k) % n;
				if (!marks[cand]) begin
					ptr = cand[INDEX_W-1:0];
					return 1;
				end
			end
			return 0;
		endfunction

		function void note_request(logic [MODE_W-1:0] m, logic [INDEX_W-1:0] idx);
			int unsigned   n;
			int unsigned   playable;
			bit            okv;
			track_result_t res;
			n = entries_in_use();
			okv = 0;
			case (m)
				MODE_SELECT: begin
					if (idx < n && !marks[idx]) begin
						ptr = idx;
						ptr_valid = 1;
						okv = 1;
					end
				end
				MODE_NEXT: okv = walk_to_playable(0);
				MODE_PREV: okv = walk_to_playable(1);
				MODE_MARK: begin
					if (ptr_valid) begin
						marks[ptr] = 1;
						okv = walk_to_playable(0);
						if (!okv) begin
							ptr_valid = 0;
							ptr = '0;
						end
					end
				end
				MODE_RESTART: begin
					foreach (marks[i])
						marks[i] = 0;
					ptr = '0;
					ptr_valid = (n != 0);
					okv = 1;
				end
				default: ;
			endcase
			playable = 0;
			for (int unsigned i = 0; i < n; i++)
				if (!marks[i])
					playable++;
			res.ok = okv;
			res.current_valid = ptr_valid;
			res.current_index = ptr_valid ? ptr : '0;
			res.playable_count = playable[COUNT_W-1:0];
			res.index_bad = (idx < n) && marks[idx];
			expected_results.push_back(res);
		endfunction

		function void check_result(track_result_t got);
			track_result_t want;
			checked++;
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.ok !== want.ok) begin
				$error("ok mismatch: expected %0d, got %0d", want.ok, got.ok);
				errors++;
			end
			if (got.current_valid !== want.current_valid) begin
				$error("current_valid mismatch: expected %0d, got %0d",
					want.current_valid, got.current_valid);
				errors++;
			end
			if (got.current_index !== want.current_index) begin
				$error("current_index mismatch: expected %0d, got %0d",
					want.current_index, got.current_index);
				errors++;
			end
			if (got.playable_count !== want.playable_count) begin
				$error("playable_count mismatch: expected %0d, got %0d",
					want.playable_count, got.playable_count);
				errors++;
			end
			if (got.index_bad !== want.index_bad) begin
				$error("index_bad mismatch: expected %0d, got %0d",
					want.index_bad, got.index_bad);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [COUNT_W-1:0] cfg_track_count = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [MODE_W-1:0]  mode = '0;
	logic [INDEX_W-1:0] index = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               ok;
	logic               current_valid;
	logic [INDEX_W-1:0] current_index;
	logic [COUNT_W-1:0] playable_count;
	logic               index_bad;

	track_pointer_scoreboard board = new();

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	bit          hold_request = 0;
	int unsigned hold_left = 0;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	int unsigned cfg_writes = 0;
	int unsigned entries = 0;

	circular_skip_mask_track_pointer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_track_count(cfg_track_count),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.index          (index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.ok             (ok),
		.current_valid  (current_valid),
		.current_index  (current_index),
		.playable_count (playable_count),
		.index_bad      (index_bad)
	);

	always #5 clk = ~clk;

	initial begin
		while (cycles < LIMIT_CYCLES)
			@(posedge clk) cycles++;
		$display("circular_skip_mask_track_pointer regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result({ok, current_valid, current_index, playable_count, index_bad});
	end

	task automatic send_item(logic [MODE_W-1:0] m, logic [INDEX_W-1:0] idx);
		in_valid <= 1'b1;
		mode <= m;
		index <= idx;
		do @(posedge clk); while (in_stall);
		board.note_request(m, idx);
		items_sent++;
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
	endtask

	// hold the sender until every outstanding result has been returned
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_track_count(logic [COUNT_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_track_count <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_track_count(value);
		entries = (value > ENTRIES_MAX) ? ENTRIES_MAX : int'(value);
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_item();
		int unsigned        r;
		logic [MODE_W-1:0]  m;
		logic [INDEX_W-1:0] idx;
		r = $urandom_range(99);
		if (r < 20)
			m = MODE_SELECT;
		else if (r < 42)
			m = MODE_NEXT;
		else if (r < 62)
			m = MODE_PREV;
		else if (r < 84)
			m = MODE_MARK;
		else if (r < 93)
			m = MODE_RESTART;
		else
			m = MODE_W'($urandom_range(5, 7));
		if (entries != 0 && $urandom_range(99) < 80)
			idx = INDEX_W'($urandom_range(0, entries - 1));
		else
			idx = INDEX_W'($urandom_range(0, 255));
		send_item(m, idx);
	endtask

	initial begin
		logic [COUNT_W-1:0] tc;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list straight after reset
		send_item(MODE_NEXT, 8'd0);
		send_item(MODE_SELECT, 8'd0);
		send_item(MODE_MARK, 8'd0);
		send_item(MODE_RESTART, 8'd0);
		send_item(3'd5, 8'd255);
		send_item(3'd7, 8'd1);

		// oversized count saturates to the full list
		write_track_count(9'd300);
		send_item(MODE_RESTART, 8'd0);
		send_item(MODE_SELECT, 8'd255);
		send_item(MODE_MARK, 8'd255);
		send_item(MODE_SELECT, 8'd255);
		send_item(MODE_PREV, 8'd0);
		send_item(MODE_NEXT, 8'd128);
		send_item(MODE_SELECT, 8'd200);

		// pointer beyond a reduced count, then mark everything playable
		write_track_count(9'd3);
		send_item(MODE_MARK, 8'd200);
		send_item(MODE_SELECT, 8'd2);
		send_item(MODE_MARK, 8'd2);
		send_item(MODE_MARK, 8'd0);
		send_item(MODE_MARK, 8'd1);
		send_item(MODE_PREV, 8'd1);
		send_item(MODE_SELECT, 8'd1);
		send_item(MODE_RESTART, 8'd2);

		// single entry: a full lap lands back on itself
		write_track_count(9'd1);
		send_item(MODE_NEXT, 8'd0);
		send_item(MODE_PREV, 8'd0);
		send_item(MODE_MARK, 8'd0);
		send_item(MODE_SELECT, 8'd0);

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			case (phase % 8)
				0: tc = COUNT_W'($urandom_range(1, 16));
				1: tc = 9'd256;
				2: tc = (phase == 2) ? 9'd511 : COUNT_W'($urandom_range(257, 511));
				3: tc = 9'd1;
				4: tc = COUNT_W'($urandom_range(2, 8));
				5: tc = 9'd0;
				6: tc = COUNT_W'($urandom_range(17, 255));
				default: tc = 9'd255;
			endcase
			write_track_count(tc);
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 76;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 76;
				end
				default: begin
					sender_idle_pct = 12;
					receiver_stall_pct = 12;
				end
			endcase
			send_item(MODE_RESTART, 8'd0);
			for (int unsigned n = 1; n < PHASE_ITEMS; n++) begin
				if (phase == 6 && n == 20)
					hold_request = 1;
				if (phase == 9 && n == 50)
					drain();
				send_random_item();
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests sent over %0d count settings (0 to 511, idle and stall mixes)",
			items_sent, cfg_writes);
		$display("%0d results checked, %0d mismatches", board.checked, board.errors);
		if (board.errors == 0 && board.pending() == 0)
			$display("circular_skip_mask_track_pointer regression: pass");
		else
			$display("circular_skip_mask_track_pointer regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/csm_pkg.sv
rtl/csm_cell.sv
rtl/csm_ring.sv
rtl/circular_skip_mask_track_pointer.sv
test/testbench.sv
